// ===== hw/rtl/mbrst_pkg.sv =====
`default_nettype none
package mbrst_pkg;

  localparam int CW     = 32;          // coordinate width
  localparam int FB     = 16;          // fraction bits
  localparam int VW     = 21;          // velocity component width
  localparam int CFG_IW = 3;           // config index width
  localparam int CFG_DW = 3 * VW;      // config data width (widest register)
  localparam int PW     = VW + CW;     // velocity * dt product width
  localparam int WIDE_W = 2 * CW + 1;  // headroom for sums before saturation

  localparam int DIV_STEPS = CW;            // one quotient bit per stage
  localparam int DIV_LAT   = DIV_STEPS + 2; // entry + steps + output stage

  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_Z = 3'd5;
  localparam logic [CFG_IW-1:0] REG_VEL   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_MOVE  = 3'd7;

  // face codes
  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_POS_X = 3'd1;
  localparam logic [2:0] FACE_NEG_Y = 3'd2;
  localparam logic [2:0] FACE_POS_Y = 3'd3;
  localparam logic [2:0] FACE_NEG_Z = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  // one slab divide: |num| << FB / |den|, signed result
  typedef struct packed {
    logic [CW-1:0] un;      // numerator magnitude
    logic [CW-1:0] ud;      // denominator magnitude
    logic          neg;     // result negative
    logic          dz;      // denominator zero
    logic [CW-1:0] dz_res;  // result when denominator zero
  } div_req_t;

  function automatic logic [CW-1:0] sat_coord(input logic [WIDE_W-1:0] v);
    logic ovf;
    ovf = (v[WIDE_W-1:CW-1] != {(WIDE_W-CW+1){v[WIDE_W-1]}});
    if (!ovf) begin
      return v[CW-1:0];
    end else if (v[WIDE_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mbrst_div.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, saturating.
module mbrst_div (
  input  wire logic                   clk_i,
  input  wire mbrst_pkg::div_req_t    req_i,
  output logic [mbrst_pkg::CW-1:0]    quo_o
);
  import mbrst_pkg::*;

  logic [CW-1:0] rem_q [DIV_STEPS+1];
  logic [CW-1:0] low_q [DIV_STEPS+1];
  logic [CW-1:0] quo_q [DIV_STEPS+1];
  logic [CW-1:0] ud_q  [DIV_STEPS+1];
  logic          ovf_q [DIV_STEPS+1];
  logic          neg_q [DIV_STEPS+1];
  logic          dz_q  [DIV_STEPS+1];
  logic [CW-1:0] dzr_q [DIV_STEPS+1];
  logic [CW-1:0] res_q;

  // entry: dividend is un << FB; quotient overflows CW bits when top part >= ud
  always_ff @(posedge clk_i) begin
    rem_q[0] <= {{(CW-FB){1'b0}}, req_i.un[CW-1:CW-FB]};
    low_q[0] <= {req_i.un[CW-FB-1:0], {FB{1'b0}}};
    quo_q[0] <= '0;
    ud_q[0]  <= req_i.ud;
    ovf_q[0] <= ({{(CW-FB){1'b0}}, req_i.un[CW-1:CW-FB]} >= req_i.ud);
    neg_q[0] <= req_i.neg;
    dz_q[0]  <= req_i.dz;
    dzr_q[0] <= req_i.dz_res;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [CW:0]   shl;
    logic          ge;
    logic [CW:0]   diff;
    assign shl  = {rem_q[k-1], low_q[k-1][CW-1]};
    assign diff = shl - {1'b0, ud_q[k-1]};
    assign ge   = (shl >= {1'b0, ud_q[k-1]});
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[CW-1:0] : shl[CW-1:0];
      low_q[k] <= {low_q[k-1][CW-2:0], 1'b0};
      quo_q[k] <= {quo_q[k-1][CW-2:0], ge};
      ud_q[k]  <= ud_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      neg_q[k] <= neg_q[k-1];
      dz_q[k]  <= dz_q[k-1];
      dzr_q[k] <= dzr_q[k-1];
    end
  end

  logic [CW-1:0] lim;
  logic [CW-1:0] qsat;
  logic [CW-1:0] res_d;

  always_comb begin
    lim   = neg_q[DIV_STEPS] ? COORD_MIN : COORD_MAX;  // 2^(CW-1) or 2^(CW-1)-1
    qsat  = (ovf_q[DIV_STEPS] || (quo_q[DIV_STEPS] > lim)) ? lim : quo_q[DIV_STEPS];
    res_d = neg_q[DIV_STEPS] ? (~qsat + 1'b1) : qsat;
    if (dz_q[DIV_STEPS]) begin
      res_d = dzr_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign quo_o = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/moving_box_ray_slab_test_top.sv =====
`default_nettype none
// Channel   Direction  Handshake                   Payload
// config    in         cfg_we_i                    cfg_idx_i, cfg_data_i
// ray       in         start_i & ~busy_o           origin_*, dir_*, ray_time, near/far_limit
// result    out        result_valid_o (one cycle)  hit, hit_distance, point_*, face_code
//
// Fully pipelined: one ray word per clock, busy_o is always low.
// Six 32-stage slab dividers (one quotient bit per stage) sit between the ray stages.
// Reset clears config registers, all stage valid bits and hit_o; other payload is not reset.
// The receiver cannot stall, so the pipeline never stops.
// The user must write config only while idle; the block does not enforce it.
module moving_box_ray_slab_test_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbrst_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [mbrst_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [mbrst_pkg::CW-1:0] origin_x_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] origin_y_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] origin_z_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] dir_x_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] dir_y_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] dir_z_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] ray_time_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] near_limit_i,
  input  wire logic signed [mbrst_pkg::CW-1:0] far_limit_i,
  output logic                               result_valid_o,
  output logic                               hit_o,
  output logic signed [mbrst_pkg::CW-1:0]    hit_distance_o,
  output logic signed [mbrst_pkg::CW-1:0]    point_x_o,
  output logic signed [mbrst_pkg::CW-1:0]    point_y_o,
  output logic signed [mbrst_pkg::CW-1:0]    point_z_o,
  output logic [2:0]                         face_code_o
);
  import mbrst_pkg::*;

  localparam int RES_LAT = DIV_LAT + 9;  // start edge to strobe

  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
    logic [CW-1:0]      near_l;
    logic [CW-1:0]      far_l;
  } ray_t;

  // ---------------- config registers ----------------
  logic [CW-1:0]     box_min_q [3];
  logic [CW-1:0]     box_max_q [3];
  logic [CFG_DW-1:0] vel_q;
  logic [CW-1:0]     move_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
      vel_q  <= '0;
      move_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_X: box_min_q[0] <= cfg_data_i[CW-1:0];
        REG_MIN_Y: box_min_q[1] <= cfg_data_i[CW-1:0];
        REG_MIN_Z: box_min_q[2] <= cfg_data_i[CW-1:0];
        REG_MAX_X: box_max_q[0] <= cfg_data_i[CW-1:0];
        REG_MAX_Y: box_max_q[1] <= cfg_data_i[CW-1:0];
        REG_MAX_Z: box_max_q[2] <= cfg_data_i[CW-1:0];
        REG_VEL:   vel_q        <= cfg_data_i;
        REG_MOVE:  move_q       <= cfg_data_i[CW-1:0];
      endcase
    end
  end

  assign busy_o = 1'b0;  // never refuses a word

  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------- stage valid bits ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic vdl_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) vdl_q[k] <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vdl_q[0] <= v5_q;
      for (int k = 1; k < DIV_LAT; k++) vdl_q[k] <= vdl_q[k-1];
      v6_q <= vdl_q[DIV_LAT-1];
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // ---------------- S1: capture ----------------
  ray_t          ray1_q, ray2_q, ray3_q, ray4_q, ray5_q;
  logic [CW-1:0] time1_q;

  always_ff @(posedge clk_i) begin
    ray1_q.org    <= {origin_z_i, origin_y_i, origin_x_i};
    ray1_q.dir    <= {dir_z_i, dir_y_i, dir_x_i};
    ray1_q.near_l <= near_limit_i;
    ray1_q.far_l  <= far_limit_i;
    time1_q       <= ray_time_i;
  end

  // ---------------- S2: elapsed move time, clamped at zero ----------------
  logic [CW:0]   dt_diff;
  logic [CW-1:0] dt2_q;
  assign dt_diff = {time1_q[CW-1], time1_q} - {move_q[CW-1], move_q};

  always_ff @(posedge clk_i) begin
    dt2_q  <= dt_diff[CW] ? '0 : dt_diff[CW-1:0];
    ray2_q <= ray1_q;
  end

  // ---------------- S3: |velocity| * dt >> FB per axis ----------------
  logic [PW-FB-1:0] mv3_d [3];
  logic             vneg3_d [3];
  logic [PW-FB-1:0] mv3_q [3];
  logic             vneg3_q [3];

  always_comb begin
    logic [VW-1:0] vel;
    logic [VW-1:0] vmag;
    logic [PW-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      vel        = vel_q[VW*i +: VW];
      vneg3_d[i] = vel[VW-1];
      vmag       = vel[VW-1] ? (~vel + 1'b1) : vel;
      prod       = {{CW{1'b0}}, vmag} * {{VW{1'b0}}, dt2_q};
      mv3_d[i]   = prod[PW-1:FB];  // magnitude truncates toward zero
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mv3_q[i]   <= mv3_d[i];
      vneg3_q[i] <= vneg3_d[i];
    end
    ray3_q <= ray2_q;
  end

  // ---------------- S4: shifted bounds, saturated ----------------
  logic [CW-1:0] lo4_d [3];
  logic [CW-1:0] hi4_d [3];
  logic [CW-1:0] lo4_q [3];
  logic [CW-1:0] hi4_q [3];

  always_comb begin
    logic [WIDE_W-1:0] mvx;
    logic [WIDE_W-1:0] le;
    logic [WIDE_W-1:0] he;
    for (int i = 0; i < 3; i++) begin
      mvx = {{(WIDE_W-(PW-FB)){1'b0}}, mv3_q[i]};
      le  = {{(WIDE_W-CW){box_min_q[i][CW-1]}}, box_min_q[i]};
      he  = {{(WIDE_W-CW){box_max_q[i][CW-1]}}, box_max_q[i]};
      lo4_d[i] = sat_coord(vneg3_q[i] ? (le - mvx) : (le + mvx));
      hi4_d[i] = sat_coord(vneg3_q[i] ? (he - mvx) : (he + mvx));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lo4_q[i] <= lo4_d[i];
      hi4_q[i] <= hi4_d[i];
    end
    ray4_q <= ray3_q;
  end

  // ---------------- S5: slab divide requests ----------------
  function automatic div_req_t mk_req(input logic [CW-1:0] bound,
                                      input logic [CW-1:0] org,
                                      input logic [CW-1:0] dir,
                                      input logic          lower);
    div_req_t    r;
    logic [CW:0] num;
    logic [CW:0] nmag;
    num      = {bound[CW-1], bound} - {org[CW-1], org};
    nmag     = num[CW] ? (~num + 1'b1) : num;
    r.un     = nmag[CW-1:0];
    r.ud     = dir[CW-1] ? (~dir + 1'b1) : dir;
    r.neg    = num[CW] ^ dir[CW-1];
    r.dz     = (dir == '0);
    // zero direction: origin on the plane counts as inside the slab
    if (num[CW]) begin
      r.dz_res = COORD_MIN;
    end else if (num != '0) begin
      r.dz_res = COORD_MAX;
    end else begin
      r.dz_res = lower ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

  div_req_t req5_q [6];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      req5_q[2*i]   <= mk_req(lo4_q[i], ray4_q.org[i], ray4_q.dir[i], 1'b1);
      req5_q[2*i+1] <= mk_req(hi4_q[i], ray4_q.org[i], ray4_q.dir[i], 1'b0);
    end
    ray5_q <= ray4_q;
  end

  // ---------------- slab dividers ----------------
  logic [CW-1:0] t_div [6];

  for (genvar j = 0; j < 6; j++) begin : g_div
    mbrst_div u_div (
      .clk_i (clk_i),
      .req_i (req5_q[j]),
      .quo_o (t_div[j])
    );
  end

  ray_t ray_dl_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    ray_dl_q[0] <= ray5_q;
    for (int k = 1; k < DIV_LAT; k++) ray_dl_q[k] <= ray_dl_q[k-1];
  end

  // ---------------- S6: per-axis near/far ----------------
  logic [CW-1:0] t6_q [6];
  logic [CW-1:0] mn6_q [3];
  logic [CW-1:0] mx6_q [3];
  ray_t          ray6_q, ray7_q, ray8_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(t_div[2*i]) < $signed(t_div[2*i+1])) begin
        mn6_q[i] <= t_div[2*i];
        mx6_q[i] <= t_div[2*i+1];
      end else begin
        mn6_q[i] <= t_div[2*i+1];
        mx6_q[i] <= t_div[2*i];
      end
    end
    for (int j = 0; j < 6; j++) t6_q[j] <= t_div[j];
    ray6_q <= ray_dl_q[DIV_LAT-1];
  end

  // ---------------- S7: entry / exit ----------------
  logic [CW-1:0] t7_q [6];
  logic [CW-1:0] tnear7_q, tfar7_q;
  logic [CW-1:0] tn01, tf01;

  assign tn01 = ($signed(mn6_q[1]) > $signed(mn6_q[0])) ? mn6_q[1] : mn6_q[0];
  assign tf01 = ($signed(mx6_q[1]) < $signed(mx6_q[0])) ? mx6_q[1] : mx6_q[0];

  always_ff @(posedge clk_i) begin
    tnear7_q <= ($signed(mn6_q[2]) > $signed(tn01)) ? mn6_q[2] : tn01;
    tfar7_q  <= ($signed(mx6_q[2]) < $signed(tf01)) ? mx6_q[2] : tf01;
    for (int j = 0; j < 6; j++) t7_q[j] <= t6_q[j];
    ray7_q <= ray6_q;
  end

  // ---------------- S8: hit test, face, point products ----------------
  logic                    hit8_d;
  logic [2:0]              face8_d;
  logic                    hit8_q;
  logic [2:0]              face8_q;
  logic [CW-1:0]           tnear8_q;
  logic signed [2*CW-1:0]  prod8_q [3];

  always_comb begin
    hit8_d = !tfar7_q[CW-1]
          && ($signed(tnear7_q) <= $signed(tfar7_q))
          && ($signed(ray7_q.near_l) <= $signed(tnear7_q))
          && ($signed(tnear7_q) <= $signed(ray7_q.far_l));
    // first plane in face order whose distance is the entry distance
    priority if (t7_q[0] == tnear7_q) face8_d = FACE_NEG_X;
    else if (t7_q[1] == tnear7_q)     face8_d = FACE_POS_X;
    else if (t7_q[2] == tnear7_q)     face8_d = FACE_NEG_Y;
    else if (t7_q[3] == tnear7_q)     face8_d = FACE_POS_Y;
    else if (t7_q[4] == tnear7_q)     face8_d = FACE_NEG_Z;
    else                              face8_d = FACE_POS_Z;
  end

  always_ff @(posedge clk_i) begin
    hit8_q   <= hit8_d;
    face8_q  <= face8_d;
    tnear8_q <= tnear7_q;
    for (int i = 0; i < 3; i++) begin
      prod8_q[i] <= $signed(tnear7_q) * $signed(ray7_q.dir[i]);
    end
    ray8_q <= ray7_q;
  end

  // ---------------- S9: hit point, output registers ----------------
  logic [CW-1:0] pt9_d [3];

  always_comb begin
    logic [2*CW-1:0]   ps;
    logic              rnd;
    logic [WIDE_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      ps  = prod8_q[i] >>> FB;
      rnd = prod8_q[i][2*CW-1] && (prod8_q[i][FB-1:0] != '0);  // toward zero
      sum = {ps[2*CW-1], ps}
          + {{(WIDE_W-CW){ray8_q.org[i][CW-1]}}, ray8_q.org[i]}
          + {{(WIDE_W-1){1'b0}}, rnd};
      pt9_d[i] = sat_coord(sum);
    end
  end

  logic          res_v_q;
  logic          hit_q;
  logic [CW-1:0] dist_q;
  logic [CW-1:0] pt_q [3];
  logic [2:0]    face_q;
  logic          show;

  assign show = v8_q & hit8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      res_v_q <= v8_q;
      hit_q   <= show;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= show ? tnear8_q : '0;
    face_q <= show ? face8_q  : FACE_NEG_X;
    for (int i = 0; i < 3; i++) pt_q[i] <= show ? pt9_d[i] : '0;
  end

  assign result_valid_o = res_v_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];
  assign face_code_o    = face_q;

`ifndef SYNTHESIS
  a_hit_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> result_valid_o)
    else $error("hit without result strobe");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (hit_distance_o == '0 && face_code_o == FACE_NEG_X
                                    && point_x_o == '0))
    else $error("miss word carries nonzero fields");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (face_code_o <= FACE_POS_Z))
    else $error("face code out of range");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, RES_LAT))
    else $error("result strobe without matching start");
`endif

endmodule
`default_nettype wire

// ===== test/moving_box_ray_slab_test_top_tb.sv =====
`timescale 1ns / 1ps

module moving_box_ray_slab_test_top_tb;
  import mbrst_pkg::*;

  localparam longint ONE = 64'sh10000;  // 1.0 in Q16.16
  localparam int LIMIT_CYCLES = 400000;
  localparam int N_PHASES = 8;
  localparam int RAND_PER_PHASE = 230;
  localparam int DRAIN_CYCLES = 60;     // pipeline latency plus margin

  typedef struct {
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] ray_time;
    logic signed [CW-1:0] near_lim;
    logic signed [CW-1:0] far_lim;
  } ray_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] distance;
    logic signed [CW-1:0] pt [3];
    logic [2:0]           face;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CW-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [CW-1:0] ray_time_i = '0, near_limit_i = '0, far_limit_i = '0;
  logic result_valid_o, hit_o;
  logic signed [CW-1:0] hit_distance_o, point_x_o, point_y_o, point_z_o;
  logic [2:0] face_code_o;

  moving_box_ray_slab_test_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .ray_time_i, .near_limit_i, .far_limit_i, .result_valid_o, .hit_o,
    .hit_distance_o, .point_x_o, .point_y_o, .point_z_o, .face_code_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Box registers as the block should hold them; updated on each write edge.
  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];
  logic [CFG_DW-1:0]    vel_word;
  logic signed [CW-1:0] move_t;

  ray_t pending_rays [$];
  hit_t expected_hits [$];
  int   idle_pct = 0;       // chance in percent that the sender skips a cycle
  int   mismatches = 0;
  int   cycles = 0;

  // Staging for the config writes issued from the stimulus block.
  logic [CFG_DW-1:0] cfg_vals [8];

  function automatic longint sat_cw(longint v);
    longint hi = (64'sd1 <<< (CW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // (a*b) >> FB truncated toward zero, magnitude capped at 2^62
  function automatic longint fx_mul(longint a, longint b);
    logic neg;
    logic [127:0] p;
    logic [63:0] ua, ub;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * 128'd1 * ub) >> FB;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // slab plane distance: (num << FB) / den, saturated; zero den follows the sign rules
  function automatic longint slab_dist(longint num, longint den, bit lower);
    logic neg;
    logic [63:0] un, ud, lim;
    logic [127:0] q;
    longint cmax = (64'sd1 <<< (CW - 1)) - 1;
    if (den == 0) begin
      if (num > 0) return cmax;
      if (num < 0) return -cmax - 1;
      return lower ? -cmax - 1 : cmax;
    end
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    lim = neg ? (64'd1 << (CW - 1)) : 64'(cmax);
    q = ({64'd0, un} << FB) / ud;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t res;
    longint dt, t [6], tnear, tfar, mv, l, h, a, b;
    logic signed [VW-1:0] vc;
    int face;
    longint cmax = (64'sd1 <<< (CW - 1)) - 1;
    res.hit = 1'b0;
    res.distance = '0;
    res.face = '0;
    for (int i = 0; i < 3; i++) res.pt[i] = '0;
    dt = longint'(r.ray_time) - longint'(move_t);
    if (dt < 0) dt = 0;
    for (int i = 0; i < 3; i++) begin
      vc = vel_word[VW*i +: VW];
      mv = fx_mul(longint'(vc), dt);
      l = sat_cw(longint'(box_lo[i]) + mv);
      h = sat_cw(longint'(box_hi[i]) + mv);
      t[2*i]   = slab_dist(l - longint'(r.org[i]), longint'(r.dir[i]), 1'b1);
      t[2*i+1] = slab_dist(h - longint'(r.org[i]), longint'(r.dir[i]), 1'b0);
    end
    tnear = -cmax - 1;
    tfar = cmax;
    for (int i = 0; i < 3; i++) begin
      a = t[2*i];
      b = t[2*i+1];
      if ((a < b ? a : b) > tnear) tnear = a < b ? a : b;
      if ((a < b ? b : a) < tfar) tfar = a < b ? b : a;
    end
    if (tfar < 0 || tnear > tfar) return res;
    if (!(longint'(r.near_lim) <= tnear && tnear <= longint'(r.far_lim))) return res;
    face = 0;
    for (int i = 5; i >= 0; i--) if (t[i] == tnear) face = i;
    res.hit = 1'b1;
    res.distance = tnear[CW-1:0];
    for (int i = 0; i < 3; i++)
      res.pt[i] = sat_cw(longint'(r.org[i]) + fx_mul(tnear, longint'(r.dir[i])));
    res.face = 3'(face);
    return res;
  endfunction

  // Driver: present the next ray word at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && pending_rays.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i      <= 1'b1;
      origin_x_i   <= pending_rays[0].org[0];
      origin_y_i   <= pending_rays[0].org[1];
      origin_z_i   <= pending_rays[0].org[2];
      dir_x_i      <= pending_rays[0].dir[0];
      dir_y_i      <= pending_rays[0].dir[1];
      dir_z_i      <= pending_rays[0].dir[2];
      ray_time_i   <= pending_rays[0].ray_time;
      near_limit_i <= pending_rays[0].near_lim;
      far_limit_i  <= pending_rays[0].far_lim;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: track config writes, predict accepted words, check results.
  always @(posedge clk_i) begin
    hit_t e;
    logic bad;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_X: box_lo[0] = cfg_data_i[CW-1:0];
          REG_MIN_Y: box_lo[1] = cfg_data_i[CW-1:0];
          REG_MIN_Z: box_lo[2] = cfg_data_i[CW-1:0];
          REG_MAX_X: box_hi[0] = cfg_data_i[CW-1:0];
          REG_MAX_Y: box_hi[1] = cfg_data_i[CW-1:0];
          REG_MAX_Z: box_hi[2] = cfg_data_i[CW-1:0];
          REG_VEL:   vel_word  = cfg_data_i;
          REG_MOVE:  move_t    = cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o && pending_rays.size() > 0) begin
        expected_hits.push_back(trace_ray(pending_rays[0]));
        void'(pending_rays.pop_front());
      end
      if (result_valid_o) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
        end else begin
          e = expected_hits.pop_front();
          bad = hit_o !== e.hit || hit_distance_o !== e.distance || point_x_o !== e.pt[0]
             || point_y_o !== e.pt[1] || point_z_o !== e.pt[2] || face_code_o !== e.face;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch cycle %0d: exp hit=%0d d=%h p=%h/%h/%h f=%0d, got hit=%0d d=%h p=%h/%h/%h f=%0d",
                       cycles, e.hit, e.distance, e.pt[0], e.pt[1], e.pt[2], e.face,
                       hit_o, hit_distance_o, point_x_o, point_y_o, point_z_o, face_code_o);
          end
        end
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                                  longint dz, longint tm, longint nl, longint fl);
    ray_t r;
    r.org[0] = ox[CW-1:0]; r.org[1] = oy[CW-1:0]; r.org[2] = oz[CW-1:0];
    r.dir[0] = dx[CW-1:0]; r.dir[1] = dy[CW-1:0]; r.dir[2] = dz[CW-1:0];
    r.ray_time = tm[CW-1:0];
    r.near_lim = nl[CW-1:0];
    r.far_lim  = fl[CW-1:0];
    return r;
  endfunction

  function automatic longint rnd_span(longint lo, longint hi);
    logic [63:0] span;
    if (hi <= lo) return lo;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // Mostly rays aimed at a point inside the box, the rest raw noise.
  function automatic ray_t rand_ray();
    ray_t r;
    longint tgt, o, sc;
    int kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 70) begin
        tgt = rnd_span(longint'(box_lo[i]), longint'(box_hi[i]));
        o = tgt + rnd_span(-20 * ONE, 20 * ONE);
        sc = $urandom_range(3);
        r.org[i] = sat_cw(o);
        r.dir[i] = ($urandom_range(15) == 0) ? '0 : sat_cw((tgt - o) >>> sc);
      end else begin
        r.org[i] = $urandom;
        r.dir[i] = ($urandom_range(7) == 0) ? '0 : $urandom;
      end
    end
    r.ray_time = kind < 85 ? rnd_span(-4 * ONE, 12 * ONE) : $urandom;
    r.near_lim = $urandom_range(3) == 0 ? $urandom : rnd_span(-2 * ONE, ONE);
    r.far_lim  = $urandom_range(3) == 0 ? $urandom : rnd_span(2 * ONE, 64'sh7fffffff);
    return r;
  endfunction

  task automatic write_box_regs();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[CFG_IW-1:0];
      cfg_data_i <= cfg_vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_rays.size() == 0 && expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    longint cmax, span;
    cmax = (64'sd1 <<< (CW - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = '0;
      box_hi[i] = '0;
    end
    vel_word = '0;
    move_t = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A few words against the all-zero box left by reset.
    pending_rays.push_back(mk_ray(-ONE, 0, 0, ONE, 0, 0, 0, -cmax - 1, cmax));
    pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0, -cmax - 1, cmax));
    wait_drained();

    // Directed words: unit box [-1,1]^3, static.
    for (int i = 0; i < 3; i++) begin
      cfg_vals[i]     = CFG_DW'(-ONE);
      cfg_vals[3 + i] = CFG_DW'(ONE);
    end
    cfg_vals[6] = '0;
    cfg_vals[7] = '0;
    write_box_regs();
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0, 0, 0, cmax));    // -x face
    pending_rays.push_back(mk_ray(4 * ONE, 0, 0, -ONE, 0, 0, 0, 0, cmax));    // +x face
    pending_rays.push_back(mk_ray(0, -4 * ONE, 0, 0, ONE, 0, 0, 0, cmax));    // -y face
    pending_rays.push_back(mk_ray(0, 4 * ONE, 0, 0, -ONE, 0, 0, 0, cmax));    // +y face
    pending_rays.push_back(mk_ray(0, 0, -4 * ONE, 0, 0, ONE, 0, 0, cmax));    // -z face
    pending_rays.push_back(mk_ray(0, 0, 4 * ONE, 0, 0, -ONE, 0, 0, cmax));    // +z face
    pending_rays.push_back(mk_ray(-ONE, 0, 0, 0, ONE, 0, 0, -cmax - 1, cmax)); // on lower plane
    pending_rays.push_back(mk_ray(ONE, 0, 0, 0, ONE, 0, 0, -cmax - 1, cmax));  // on upper plane
    pending_rays.push_back(mk_ray(2 * ONE, 0, 0, 0, ONE, 0, 0, -cmax - 1, cmax)); // outside slab
    pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0, -cmax - 1, cmax));     // zero direction
    pending_rays.push_back(mk_ray(0, 0, 0, ONE, ONE, ONE, 0, -cmax - 1, cmax)); // origin inside
    pending_rays.push_back(mk_ray(4 * ONE, 0, 0, ONE, 0, 0, 0, -cmax - 1, cmax)); // box behind
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0, 0, 4 * ONE, cmax)); // past near
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0, 0, 0, 2 * ONE));   // short of far
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0, 0, 5 * ONE, ONE)); // inverted window
    pending_rays.push_back(mk_ray(-4 * ONE, -4 * ONE, -4 * ONE, ONE, ONE, ONE, 0, 0, cmax)); // corner
    pending_rays.push_back(mk_ray(cmax, -cmax - 1, cmax, -cmax - 1, cmax, 1, cmax, -cmax - 1,
                                  cmax));                                        // field extremes
    pending_rays.push_back(mk_ray(-cmax - 1, cmax, -cmax - 1, cmax, -cmax - 1, -1, -cmax - 1,
                                  cmax, -cmax - 1));
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, 1, 0, 0, 0, -cmax - 1, cmax)); // tiny direction
    wait_drained();

    // Moving box with extreme velocity so the shifted bounds saturate.
    cfg_vals[6] = {1'b0, {(VW-1){1'b1}}, 1'b1, {(VW-1){1'b0}}, 1'b0, {(VW-1){1'b1}}};
    cfg_vals[7] = CFG_DW'(-cmax - 1);
    write_box_regs();
    pending_rays.push_back(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0, cmax, -cmax - 1, cmax));
    pending_rays.push_back(mk_ray(0, 0, 0, ONE, ONE, ONE, 2 * ONE, -cmax - 1, cmax));
    wait_drained();

    // Random phases, each with its own box, velocity and gap pattern.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 68;
        2: idle_pct = 0;
        default: idle_pct = 32;
      endcase
      for (int i = 0; i < 3; i++) begin
        span = rnd_span(ONE / 4, 8 * ONE);
        cfg_vals[i]     = CFG_DW'(rnd_span(-8 * ONE, 8 * ONE));
        cfg_vals[3 + i] = CFG_DW'(longint'($signed(cfg_vals[i][CW-1:0])) + span);
        if (p == 2) begin
          // full-range box
          cfg_vals[i]     = CFG_DW'(-cmax - 1);
          cfg_vals[3 + i] = CFG_DW'(cmax);
        end else if (p == 5) begin
          // inverted box
          cfg_vals[i + 3] = CFG_DW'(longint'($signed(cfg_vals[i][CW-1:0])) - span);
        end
      end
      cfg_vals[6] = (p % 2) ? {$urandom, $urandom} :
                    {{2{$urandom_range(1) ? 21'h1fe000 : 21'h002000}}, 21'h000000};
      cfg_vals[7] = (p == 7) ? CFG_DW'(cmax) : CFG_DW'(rnd_span(-2 * ONE, 4 * ONE));
      write_box_regs();
      for (int k = 0; k < RAND_PER_PHASE; k++) pending_rays.push_back(rand_ray());
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
